### rtl/bbpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbpe_pkg: shared types and constants of the Bezier patch evaluator
// Holds the command codes, the sequencer states and the cubic power-basis
// matrix that turns [t^3 t^2 t 1] into the four Bernstein weights.
// ----------------------------------------------------------------------------
package bbpe_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Power basis to Bernstein basis, row m is the power t^(3-m).
  localparam int BASIS [16] = '{-1, 3, -3, 1, 3, -6, 3, 0, -3, 3, 0, 0, 1, 0, 0, 0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW,
    ST_BERN,
    ST_TENS,
    ST_MAC,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

### rtl/bbpe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbpe_ram: generic single-port-write, registered-read RAM
// One write port and one read port; read data is registered and appears in
// the cycle after the read address.
// ----------------------------------------------------------------------------
module bbpe_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/bicubic_bezier_patch_eval_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval_top: bicubic Bezier patch evaluator
// Stores 16 control points and evaluates the patch at grid positions.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one beat per command. s_tuser selects the kind:
// a load beat writes control point point_index, an evaluate beat asks for the
// surface point at grid indices (u_step, v_step), each clamped to the
// tessellation count n. Evaluation returns one master-stream beat with the
// saturated x, y and z coordinates; a load beat returns nothing.
// A load is taken and the block is ready again at once.
// An evaluate beat runs through one shared multiplier under a sequencer:
// two restoring divisions form u and v, then 4 power products and 16
// tensor weights, then 48 coordinate products, two partial products per point.
// The result sits in an output register, so the next command can be taken
// while the receiver stalls; a further evaluate waits at its end until the
// output register is free. The tessellation register resets to 10, a value
// of zero acts as one. Control point storage is not cleared by reset.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval_top
  import bbpe_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_W  = ((20 + 3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_data,     // tessellation
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // point_index, coord_x, coord_y, coord_z, u_step, v_step (lowest first)
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tuser,      // cmd
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata       // surf_x, surf_y, surf_z
);

  localparam int CW    = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int LO_W  = CW / 2;
  localparam int HI_W  = CW - LO_W;
  localparam int ONE_W = F + 1;
  localparam int BW    = F + 4;
  localparam int WW    = F + 8;
  localparam int MW    = (LO_W + 1 > WW) ? LO_W + 1 : WW;
  localparam int PW    = 2 * MW;
  localparam int AW    = PW + LO_W + 5;
  localparam int NW    = F + 9;
  localparam int CNT_W = $clog2(NW + 1);

  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (F - 1);
  localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (F - 1);
  localparam logic signed [AW-1:0] SAT_HI = {{(AW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  state_t state, state_next;

  logic [7:0]        tess;
  logic [7:0]        n_eff;
  logic [7:0]        n_q;
  logic [7:0]        j_step;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        ph;
  logic              sel;
  logic [1:0]        axis;
  logic [NW-1:0]     num;
  logic [7:0]        rem;
  logic [ONE_W-1:0]  quo;
  logic [ONE_W-1:0]  u, v, u2, u3, v2, v3;
  logic signed [BW-1:0] bu [4];
  logic signed [BW-1:0] bv [4];
  logic signed [WW-1:0] wt [16];
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [CW-1:0]     res [3];
  logic [CW-1:0]     out_x, out_y, out_z;

  logic              accept, do_load;
  logic [7:0]        u_in, v_in, u_clamp, v_clamp;
  logic [8:0]        rem2;
  logic              ge;
  logic [ONE_W-1:0]  quo_next;
  logic [NW-1:0]     num_j;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] rnd_p;
  logic [CW-1:0]     coord;
  logic [3*CW-1:0]   rdata;
  logic signed [BW-1:0] pwu [4];
  logic signed [BW-1:0] pwv [4];
  logic signed [BW-1:0] bu_c [4];
  logic signed [BW-1:0] bv_c [4];
  logic signed [AW-1:0] acc_sum, rs, sat;
  logic              out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign do_load  = accept && (s_tuser == CMD_LOAD);
  assign n_eff    = (tess == 8'd0) ? 8'd1 : tess;
  assign u_in     = s_tdata[4 + 3 * CW +: 8];
  assign v_in     = s_tdata[12 + 3 * CW +: 8];
  assign u_clamp  = (u_in > n_eff) ? n_eff : u_in;
  assign v_clamp  = (v_in > n_eff) ? n_eff : v_in;
  assign out_free = !m_tvalid || m_tready;

  bbpe_ram #(.WIDTH(3 * CW), .DEPTH(16)) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (s_tdata[3:0]),
    .wdata (s_tdata[4 +: 3 * CW]),
    .raddr (cnt[3:0]),
    .rdata (rdata)
  );

  // Restoring divider step, one quotient bit per cycle.
  assign rem2     = {rem, num[NW-1]};
  assign ge       = rem2 >= {1'b0, n_q};
  assign quo_next = {quo[ONE_W-2:0], ge};
  assign num_j    = NW'({j_step, {F{1'b0}}}) + NW'(n_q >> 1);

  always_comb begin
    case (axis)
      2'd0:    coord = rdata[0 +: CW];
      2'd1:    coord = rdata[CW +: CW];
      default: coord = rdata[2 * CW +: CW];
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_POW: begin
        case (cnt[1:0])
          2'd0:    begin mul_a = MW'(u);  mul_b = MW'(u); end
          2'd1:    begin mul_a = MW'(u2); mul_b = MW'(u); end
          2'd2:    begin mul_a = MW'(v);  mul_b = MW'(v); end
          default: begin mul_a = MW'(v2); mul_b = MW'(v); end
        endcase
      end
      ST_TENS: begin
        mul_a = MW'(bu[cnt[3:2]]);
        mul_b = MW'(bv[cnt[1:0]]);
      end
      ST_MAC: begin
        mul_b = MW'(wt[cnt[3:0]]);
        if (ph == 2'd1) begin
          mul_a = signed'(MW'(coord[LO_W-1:0]));
        end else begin
          mul_a = MW'(signed'(coord[CW-1 -: HI_W]));
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd_p = (prod + HALF_P) >>> F;

  // Bernstein weights from the power terms.
  always_comb begin
    pwu[0] = signed'(BW'(u3));
    pwu[1] = signed'(BW'(u2));
    pwu[2] = signed'(BW'(u));
    pwu[3] = signed'(BW'(1) << F);
    pwv[0] = signed'(BW'(v3));
    pwv[1] = signed'(BW'(v2));
    pwv[2] = signed'(BW'(v));
    pwv[3] = signed'(BW'(1) << F);
    for (int k = 0; k < 4; k++) begin
      bu_c[k] = '0;
      bv_c[k] = '0;
      for (int m = 0; m < 4; m++) begin
        bu_c[k] = bu_c[k] + pwu[m] * BW'(BASIS[m * 4 + k]);
        bv_c[k] = bv_c[k] + pwv[m] * BW'(BASIS[m * 4 + k]);
      end
    end
  end

  // The high partial product carries the weight of the low chunk width.
  assign acc_sum = acc + (AW'(prod) <<< LO_W);
  assign rs      = (acc_sum + HALF_A) >>> F;
  assign sat     = (rs > SAT_HI) ? SAT_HI : ((rs < SAT_LO) ? SAT_LO : rs);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == CMD_EVAL)) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == CNT_W'(NW - 1) && sel) begin
          state_next = ST_POW;
        end
      end
      ST_POW: begin
        if (ph[0] && cnt[1:0] == 2'd3) begin
          state_next = ST_BERN;
        end
      end
      ST_BERN: state_next = ST_TENS;
      ST_TENS: begin
        if (ph[0] && cnt[3:0] == 4'd15) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (ph == 2'd3 && cnt[3:0] == 4'd15 && axis == 2'd2) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tess     <= 8'd10;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tess <= cfg_data;
      end
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        n_q    <= n_eff;
        j_step <= v_clamp;
        num    <= NW'({u_clamp, {F{1'b0}}}) + NW'(n_eff >> 1);
        rem    <= '0;
        quo    <= '0;
        cnt    <= '0;
        sel    <= 1'b0;
        ph     <= '0;
      end
      ST_DIV: begin
        rem <= ge ? 8'(rem2 - {1'b0, n_q}) : rem2[7:0];
        quo <= quo_next;
        num <= num << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          if (!sel) begin
            u   <= quo_next;
            sel <= 1'b1;
            num <= num_j;
          end else begin
            v <= quo_next;
          end
        end
      end
      ST_POW: begin
        ph <= {1'b0, !ph[0]};
        if (ph[0]) begin
          cnt <= cnt + 1'b1;
          case (cnt[1:0])
            2'd0:    u2 <= rnd_p[ONE_W-1:0];
            2'd1:    u3 <= rnd_p[ONE_W-1:0];
            2'd2:    v2 <= rnd_p[ONE_W-1:0];
            default: v3 <= rnd_p[ONE_W-1:0];
          endcase
        end
      end
      ST_BERN: begin
        bu  <= bu_c;
        bv  <= bv_c;
        cnt <= '0;
        ph  <= '0;
      end
      ST_TENS: begin
        ph <= {1'b0, !ph[0]};
        if (ph[0]) begin
          wt[cnt[3:0]] <= rnd_p[WW-1:0];
          cnt          <= cnt + 1'b1;
          if (cnt[3:0] == 4'd15) begin
            cnt  <= '0;
            axis <= '0;
            acc  <= '0;
          end
        end
      end
      ST_MAC: begin
        ph <= ph + 1'b1;
        if (ph == 2'd2) begin
          acc <= acc + AW'(prod);
        end
        if (ph == 2'd3) begin
          acc <= acc_sum;
          cnt <= cnt + 1'b1;
          if (cnt[3:0] == 4'd15) begin
            res[axis] <= sat[CW-1:0];
            acc       <= '0;
            cnt       <= '0;
            axis      <= axis + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_x <= res[0];
          out_y <= res[1];
          out_z <= res[2];
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  assign m_tdata = OUT_W'({out_z, out_y, out_x});

endmodule
`default_nettype wire

### rtl/bbpe_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbpe_check: port-level checks of the Bezier patch evaluator
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module bbpe_check
  import bbpe_pkg::*;
#(
  parameter int OUT_W = 96
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             s_tuser,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed under stall");

  // An evaluate beat occupies the sequencer on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_EVAL |=> !s_tready)
    else $error("ready right after an evaluate beat");

  // A load beat never produces a result.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_LOAD && !m_tvalid |=> !m_tvalid)
    else $error("result after a load beat");

endmodule

bind bicubic_bezier_patch_eval_top bbpe_check #(.OUT_W(OUT_W)) u_bbpe_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Bezier patch evaluator testbench
// Loads control points and asks for surface points over several tessellation
// settings. Every answer is checked against a bit-exact fixed-point
// predictor. Both stream sides idle at random in bursts, and one long
// receiver stall fills the block so that it has to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import bbpe_pkg::*;

  localparam int IN_W  = 120;
  localparam int OUT_W = 96;
  localparam int ONE   = 1 << 16;

  typedef longint arr4_t [4];
  typedef longint arr16_t [16];

  typedef struct {
    logic               cmd;
    logic [3:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         u;
    logic [7:0]         v;
  } cmd_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } surf_pt_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [7:0]      cfg_data;
  logic            s_tvalid;
  wire             s_tready;
  logic [IN_W-1:0] s_tdata;   // point_index, coord_x, coord_y, coord_z, u_step, v_step
  logic            s_tuser;   // cmd
  wire             m_tvalid;
  logic            m_tready;
  wire [OUT_W-1:0] m_tdata;   // surf_x, surf_y, surf_z

  bicubic_bezier_patch_eval_top dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Commands waiting for the driver, and surface points waiting for the output.
  cmd_item_t pending_cmds[$];
  surf_pt_t  expected_pts[$];
  cmd_item_t cur_cmd;

  // Predictor copy of the block state.
  logic [7:0] tess_reg;
  arr16_t     pts_x, pts_y, pts_z;

  int  errors = 0;
  int  n_loads = 0;
  int  n_evals = 0;
  bit  idle_on = 1;
  bit  took = 0;
  int  src_gap = 0;
  int  sink_hold = 0;
  int  long_hold_req = 0;

  initial clk = 0;
  always #10 clk = ~clk;

  // Bernstein weights for one grid index, exact and signed.
  function automatic arr4_t bern_weights(input int unsigned step, input int unsigned n);
    longint unsigned t, t2, t3;
    longint pw [4];
    arr4_t w;
    if (step > n) step = n;
    t  = ((longint'(step) << 16) + (n >> 1)) / n;
    t2 = (t * t + ONE / 2) >> 16;
    t3 = (t2 * t + ONE / 2) >> 16;
    pw[0] = t3; pw[1] = t2; pw[2] = t; pw[3] = ONE;
    for (int k = 0; k < 4; k++) begin
      w[k] = 0;
      for (int m = 0; m < 4; m++) w[k] += pw[m] * longint'(BASIS[m * 4 + k]);
    end
    return w;
  endfunction

  // Weighted sum of one coordinate over the 16 points, rounded and saturated.
  function automatic logic signed [31:0] blend_axis(input arr16_t p, input arr16_t wt);
    longint a, b, r;
    a = 0;
    b = 0;
    for (int k = 0; k < 16; k++) begin
      a += (p[k] >>> 16) * wt[k];
      b += (p[k] & 64'hFFFF) * wt[k];
    end
    b += ONE / 2;
    r = a + (b >>> 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic surf_pt_t surface_point(input logic [7:0] u, input logic [7:0] v);
    arr4_t bu, bv;
    arr16_t wt;
    int unsigned n;
    surf_pt_t s;
    n = (tess_reg == 0) ? 1 : tess_reg;
    bu = bern_weights(u, n);
    bv = bern_weights(v, n);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        wt[r * 4 + c] = (bu[r] * bv[c] + ONE / 2) >>> 16;
    s.x = blend_axis(pts_x, wt);
    s.y = blend_axis(pts_y, wt);
    s.z = blend_axis(pts_z, wt);
    return s;
  endfunction

  // Accepted input beats update the predictor; output beats are checked.
  always @(posedge clk) begin
    surf_pt_t got, want;
    if (!rst && s_tvalid && s_tready) begin
      took = 1;
      if (cur_cmd.cmd == CMD_LOAD) begin
        pts_x[cur_cmd.idx] = cur_cmd.x;
        pts_y[cur_cmd.idx] = cur_cmd.y;
        pts_z[cur_cmd.idx] = cur_cmd.z;
        n_loads++;
      end else begin
        expected_pts.push_back(surface_point(cur_cmd.u, cur_cmd.v));
        n_evals++;
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[31:0];
      got.y = m_tdata[63:32];
      got.z = m_tdata[95:64];
      if (expected_pts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat x=%h y=%h z=%h", got.x, got.y, got.z);
      end else begin
        want = expected_pts.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                     want.x, want.y, want.z, got.x, got.y, got.z);
        end
      end
    end
  end

  // Source side: holds a beat until it is taken, then maybe idles a little.
  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || took) begin
      took = 0;
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 0;
      end else if (pending_cmds.size() > 0) begin
        it = pending_cmds.pop_front();
        cur_cmd = it;
        s_tvalid <= 1;
        s_tuser <= it.cmd;
        s_tdata <= {4'b0, it.v, it.u, it.z, it.y, it.x, it.idx};
        if (idle_on && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 3);
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Sink side: random short stalls, plus one long stall on request.
  always @(negedge clk) begin
    if (long_hold_req > 0) begin
      sink_hold = long_hold_req;
      long_hold_req = 0;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      sink_hold = $urandom_range(0, 2);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_load(input logic [3:0] idx, input logic signed [31:0] x,
                          input logic signed [31:0] y, input logic signed [31:0] z);
    cmd_item_t it;
    it.cmd = CMD_LOAD; it.idx = idx; it.x = x; it.y = y; it.z = z;
    it.u = $urandom; it.v = $urandom;
    pending_cmds.push_back(it);
  endtask

  task automatic add_eval(input logic [7:0] u, input logic [7:0] v);
    cmd_item_t it;
    it.cmd = CMD_EVAL; it.idx = $urandom; it.x = $urandom; it.y = $urandom;
    it.z = $urandom; it.u = u; it.v = v;
    pending_cmds.push_back(it);
  endtask

  // Waits until every beat is sent and answered, then lets the block settle.
  task automatic drain();
    while (pending_cmds.size() > 0 || s_tvalid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (320) @(posedge clk);
  endtask

  task automatic write_tess(input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_data <= val;
    tess_reg = val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] rand_step();
    int unsigned n;
    n = (tess_reg == 0) ? 1 : tess_reg;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return n;
      2: return 0;
      default: return $urandom_range(0, n);
    endcase
  endfunction

  initial begin
    logic [7:0] tess_plan [6];
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    s_tvalid = 0;
    s_tuser = 0;
    s_tdata = '0;
    m_tready = 0;
    tess_reg = 10;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: all 16 points with x at the coordinate extremes, then corners,
    // the middle and indices beyond the grid, which clamp to the edge.
    for (int k = 0; k < 16; k++)
      add_load(k, (k % 2) ? 32'sh7FFFFFFF : 32'sh80000000,
               (k < 8) ? 32'sh7FFFFFFF : 32'sh00010000, -32'sh1 - k);
    add_eval(0, 0);
    add_eval(10, 10);
    add_eval(0, 10);
    add_eval(5, 5);
    add_eval(255, 3);
    add_eval(11, 255);
    for (int k = 0; k < 16; k++) add_load(k, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    add_eval(4, 7);
    add_eval(10, 0);
    drain();

    // Reset value first, then one grid step, the largest grid, zero that
    // acts as one, a tiny grid and a random one; the last phase runs flat out.
    tess_plan = '{8'd10, 8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(2, 254))};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_tess(tess_plan[ph]);
      idle_on = (ph != 5);
      for (int k = 0; k < 70; k++) begin
        if ($urandom_range(0, 2) == 0)
          add_load($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
        else
          add_eval(rand_step(), rand_step());
      end
      // Long receiver stall while the source keeps offering beats.
      if (ph == 1) begin
        @(negedge clk);
        long_hold_req = 2000;
      end
      drain();
    end

    $display("Covered %0d loads and %0d evaluations over six tessellation settings,",
             n_loads, n_evals);
    $display("including clamped indices, a zero setting and a long output stall.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule
